@@ hdl/bvg_pkg.sv @@
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared widths, register indexes, reset values, the level curve and the
// payload types of the battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int unsigned RAW_W      = 12;
  localparam int unsigned MV_W       = 16;
  localparam int unsigned CUR_W      = 16;
  localparam int unsigned PCT_W      = 10;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned BAND_W     = 10;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_BAND      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_SCALE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE  = 3'd3;

  localparam logic [THR_W-1:0]   JUMP_THRESHOLD_RST = 12'd200;
  localparam logic [BAND_W-1:0]  HOLD_BAND_RST      = 10'd10;
  localparam logic [SCALE_W-1:0] VOLTAGE_SCALE_RST  = 16'd1240;
  localparam logic [SCALE_W-1:0] CURRENT_SCALE_RST  = 16'd1193;

  localparam int unsigned WINDOW_LEN_DEF  = 8;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // (raw << 16) / ref needs this many quotient bits
  localparam int unsigned RATIO_W = RAW_W + 16;

  // x / 25 == (x * DIV25_MAGIC) >> DIV25_SHIFT for every 32-bit x
  localparam logic [31:0] DIV25_MAGIC = 32'h51EB_851F;
  localparam int unsigned DIV25_SHIFT = 35;

  // piecewise-linear level curve over mV * 100
  localparam int unsigned LVL_A_W    = 23;
  localparam int unsigned SEG_N      = 12;
  localparam int unsigned SEG_IDX_W  = $clog2(SEG_N);
  localparam int unsigned SEG_DIV_W  = 7;
  localparam int unsigned LDIV_NUM_W = 16;

  localparam logic [LVL_A_W-1:0] SEG_BASE [SEG_N] = '{
    23'd417900, 23'd406300, 23'd394900, 23'd384500, 23'd376000, 23'd369500,
    23'd364800, 23'd361300, 23'd357600, 23'd352100, 23'd348000, 23'd342600
  };
  localparam logic [PCT_W-1:0] SEG_OFFSET [SEG_N] = '{
    10'd1000, 10'd900, 10'd800, 10'd700, 10'd600, 10'd500,
    10'd400,  10'd300, 10'd200, 10'd100, 10'd50,  10'd0
  };
  localparam logic [SEG_DIV_W-1:0] SEG_DIV [SEG_N] = '{
    7'd0,  7'd116, 7'd114, 7'd104, 7'd85, 7'd65,
    7'd47, 7'd35,  7'd37,  7'd55,  7'd41, 7'd54
  };

  localparam logic [PCT_W-1:0] LEVEL_FULL = 10'd1000;

  typedef struct packed {
    logic [RAW_W-1:0] battery_raw;
    logic [RAW_W-1:0] reference_raw;
    logic [RAW_W-1:0] charge_raw;
    logic             charger_present;
  } in_t;

  typedef struct packed {
    logic [MV_W-1:0]  voltage_mv;
    logic [CUR_W-1:0] charge_current;
    logic [PCT_W-1:0] percent_tenths;
  } out_t;

  typedef struct packed {
    logic [THR_W-1:0]   jump_threshold;
    logic [BAND_W-1:0]  hold_band;
    logic [SCALE_W-1:0] voltage_scale;
    logic [SCALE_W-1:0] current_scale;
  } cfg_t;

  // converted sample handed from the front to the back
  typedef struct packed {
    logic [MV_W-1:0]  raw_mv;
    logic [CUR_W-1:0] charge_current;
    logic             charging;
  } job_t;

endpackage

@@ hdl/bvg_div.sv @@
// ----------------------------------------------------------------------------
// bvg_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvg_div #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  always_comb begin
    trial     = {rem_q, num_q[NUM_W-1]};
    ge        = trial >= {1'b0, den_q};
    trial_sub = trial - {1'b0, den_q};
    cnt_d     = cnt_q;
    busy_d    = busy_q;
    done_d    = 1'b0;
    num_d     = num_q;
    den_d     = den_q;
    rem_d     = rem_q;
    if (start_i) begin
      num_d  = num_i;
      den_d  = den_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // numerator shifts out at the top, quotient bits shift in at the bottom
      rem_d = ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

@@ hdl/bvg_queue.sv @@
// ----------------------------------------------------------------------------
// bvg_queue
// Small first-in first-out queue of register entries.
// ----------------------------------------------------------------------------
module bvg_queue #(
  parameter int unsigned DEPTH = 2,
  parameter type         data_t = logic [7:0]
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  data_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output data_t data_o,
  output logic  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  data_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/bvg_front.sv @@
// ----------------------------------------------------------------------------
// bvg_front
// Takes raw ADC samples and converts them to millivolts and charge current
// with one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
module bvg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bvg_pkg::cfg_t cfg_i,
  input  logic          push_i,
  input  bvg_pkg::in_t  item_i,
  output logic          full_o,
  output logic          job_push_o,
  output bvg_pkg::job_t job_o,
  input  logic          job_full_i
);

  import bvg_pkg::*;

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_DIVB  = 4'd1;
  localparam logic [3:0] F_MULV  = 4'd2;
  localparam logic [3:0] F_CHG   = 4'd3;
  localparam logic [3:0] F_DIVC  = 4'd4;
  localparam logic [3:0] F_MULC  = 4'd5;
  localparam logic [3:0] F_MULR  = 4'd6;
  localparam logic [3:0] F_SCALE = 4'd7;
  localparam logic [3:0] F_PUSH  = 4'd8;

  logic [3:0]         state_q, state_d;
  logic [RAW_W-1:0]   rraw_q, rraw_d;
  logic [RAW_W-1:0]   craw_q, craw_d;
  logic               chg_q, chg_d;
  logic               ref_zero_q, ref_zero_d;
  logic [31:0]        ratio_q, ratio_d;
  logic [63:0]        prod_q, prod_d;
  logic               prod_en;
  logic [MV_W-1:0]    raw_q, raw_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic [31:0]        mul_a, mul_b;
  logic [28:0]        q25;
  logic [31:0]        cur_x10;
  logic               div_start, div_done;
  logic [RATIO_W-1:0] div_num, div_quot;
  logic [RAW_W-1:0]   div_den;
  logic               accept;

  assign full_o = state_q != F_IDLE;
  assign accept = push_i && (state_q == F_IDLE);

  // battery divide starts straight from the port, charge divide from the latch
  assign div_num = (state_q == F_IDLE) ? {item_i.battery_raw, 16'b0} : {craw_q, 16'b0};
  assign div_den = (state_q == F_IDLE) ? item_i.reference_raw : rraw_q;

  bvg_div #(
    .NUM_W (RATIO_W),
    .DEN_W (RAW_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    unique case (state_q)
      F_MULV: begin
        mul_a = ratio_q;
        mul_b = {16'b0, cfg_i.voltage_scale};
      end
      F_MULC: begin
        mul_a = ratio_q;
        mul_b = {16'b0, cfg_i.current_scale};
      end
      default: begin
        mul_a = prod_q[31:0];
        mul_b = DIV25_MAGIC;
      end
    endcase
    prod_d  = {32'b0, mul_a} * {32'b0, mul_b};
    q25     = prod_q[63:DIV25_SHIFT];
    cur_x10 = {3'b0, q25} * 32'd10;
  end

  always_comb begin
    state_d    = state_q;
    rraw_d     = rraw_q;
    craw_d     = craw_q;
    chg_d      = chg_q;
    ref_zero_d = ref_zero_q;
    ratio_d    = ratio_q;
    raw_d      = raw_q;
    cur_d      = cur_q;
    prod_en    = 1'b0;
    div_start  = 1'b0;
    job_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          rraw_d     = item_i.reference_raw;
          craw_d     = item_i.charge_raw;
          chg_d      = item_i.charger_present;
          ref_zero_d = item_i.reference_raw == '0;
          if (item_i.reference_raw == '0) begin
            // zero reference gives an all-ones ratio
            ratio_d = '1;
            state_d = F_MULV;
          end else begin
            div_start = 1'b1;
            state_d   = F_DIVB;
          end
        end
      end
      F_DIVB: begin
        if (div_done) begin
          ratio_d = {{(32 - RATIO_W){1'b0}}, div_quot};
          state_d = F_MULV;
        end
      end
      F_MULV: begin
        prod_en = 1'b1;
        state_d = F_CHG;
      end
      F_CHG: begin
        // (ratio * scale) >> 15, low 16 bits
        raw_d = prod_q[30:15];
        if (!chg_q) begin
          cur_d   = '0;
          state_d = F_PUSH;
        end else if (ref_zero_q) begin
          ratio_d = '1;
          state_d = F_MULC;
        end else begin
          div_start = 1'b1;
          state_d   = F_DIVC;
        end
      end
      F_DIVC: begin
        if (div_done) begin
          ratio_d = {{(32 - RATIO_W){1'b0}}, div_quot};
          state_d = F_MULC;
        end
      end
      F_MULC: begin
        prod_en = 1'b1;
        state_d = F_MULR;
      end
      F_MULR: begin
        // divide the low word by 25 through the reciprocal
        prod_en = 1'b1;
        state_d = F_SCALE;
      end
      F_SCALE: begin
        cur_d   = cur_x10[31:16];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        job_push_o = 1'b1;
        if (!job_full_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rraw_q     <= rraw_d;
    craw_q     <= craw_d;
    chg_q      <= chg_d;
    ref_zero_q <= ref_zero_d;
    ratio_q    <= ratio_d;
    raw_q      <= raw_d;
    cur_q      <= cur_d;
    if (prod_en) begin
      prod_q <= prod_d;
    end
  end

  assign job_o = '{raw_mv: raw_q, charge_current: cur_q, charging: chg_q};

endmodule

@@ hdl/bvg_back.sv @@
// ----------------------------------------------------------------------------
// bvg_back
// Jump test, averaging window, level curve and hold filter for one converted
// sample at a time.
// ----------------------------------------------------------------------------
module bvg_back #(
  parameter int unsigned WINDOW_LEN = bvg_pkg::WINDOW_LEN_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bvg_pkg::cfg_t cfg_i,
  input  bvg_pkg::job_t job_i,
  input  logic          job_empty_i,
  output logic          job_pop_o,
  output logic          res_push_o,
  output bvg_pkg::out_t res_o,
  input  logic          res_full_i
);

  import bvg_pkg::*;

  localparam int unsigned PTR_W   = $clog2(WINDOW_LEN);
  localparam int unsigned CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int unsigned DEN_W   = SEG_DIV_W;

  // sum / WINDOW_LEN as (sum * AVG_MUL) >> AVG_SH, exact for every 16-bit sum
  localparam int unsigned AVG_MUL_W = MV_W + 1;
  localparam int unsigned AVG_SH    = MV_W + $clog2(WINDOW_LEN);
  localparam logic [AVG_MUL_W-1:0] AVG_MUL =
    AVG_MUL_W'(((32'd1 << AVG_SH) + WINDOW_LEN - 1) / WINDOW_LEN);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_CLASS = 3'd1;
  localparam logic [2:0] B_AVG   = 3'd2;
  localparam logic [2:0] B_LEVEL = 3'd3;
  localparam logic [2:0] B_SEG   = 3'd4;
  localparam logic [2:0] B_LDIV  = 3'd5;
  localparam logic [2:0] B_PUSH  = 3'd6;

  logic [MV_W-1:0]    win_mem [WINDOW_LEN];
  logic [MV_W-1:0]    old_q;
  logic               win_we;

  logic [2:0]         state_q, state_d;
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]   fill_cnt_q, fill_cnt_d;
  logic [MV_W-1:0]    fill_q, fill_d;
  logic [MV_W-1:0]    sum_q, sum_d;
  logic [MV_W-1:0]    last_q, last_d;
  logic [PCT_W-1:0]   held_q, held_d;

  logic [MV_W-1:0]    raw_q, raw_d;
  logic [CUR_W-1:0]   cur_q, cur_d;
  logic               chg_q, chg_d;
  logic [MV_W-1:0]    volt_q, volt_d;
  logic [LVL_A_W-1:0] a_q, a_d;
  logic [PCT_W-1:0]   seg_off_q, seg_off_d;
  logic [PCT_W-1:0]   lvl_q, lvl_d;

  logic [MV_W:0]      hi_lim, lo_sum;
  logic               jump;
  logic [MV_W-1:0]    oldest, sum_shift, sum_fill;
  logic [31:0]        fill_prod;
  logic [MV_W+AVG_MUL_W-1:0] avg_prod;
  logic [MV_W-1:0]    avg_quot;
  logic               seg_hit;
  logic [SEG_IDX_W-1:0] seg_idx;
  logic [LVL_A_W-1:0] seg_diff;
  logic [PCT_W:0]     band_lim;
  logic               take;
  logic [PCT_W-1:0]   pct;

  logic                  div_start, div_done;
  logic [LDIV_NUM_W-1:0] div_num, div_quot;
  logic [DEN_W-1:0]      div_den;

  // window slots not rewritten since the last refill read as the fill value
  always_comb begin
    hi_lim    = {1'b0, last_q} + {{(MV_W + 1 - THR_W){1'b0}}, cfg_i.jump_threshold};
    lo_sum    = {1'b0, raw_q} + {{(MV_W + 1 - THR_W){1'b0}}, cfg_i.jump_threshold};
    jump      = ({1'b0, raw_q} > hi_lim) || (lo_sum < {1'b0, last_q});
    oldest    = (fill_cnt_q < CNT_W'(WINDOW_LEN)) ? fill_q : old_q;
    sum_shift = sum_q - oldest + raw_q;
    fill_prod = {16'b0, raw_q} * 32'(WINDOW_LEN);
    sum_fill  = fill_prod[MV_W-1:0];
    avg_prod  = {{AVG_MUL_W{1'b0}}, sum_q} * {{MV_W{1'b0}}, AVG_MUL};
    avg_quot  = MV_W'(avg_prod >> AVG_SH);
  end

  // first segment whose base the scaled voltage reaches
  always_comb begin
    seg_hit = 1'b0;
    seg_idx = '0;
    for (int i = SEG_N - 1; i >= 0; i--) begin
      if (a_q >= SEG_BASE[i]) begin
        seg_hit = 1'b1;
        seg_idx = SEG_IDX_W'(i);
      end
    end
    seg_diff = a_q - SEG_BASE[seg_idx];
  end

  always_comb begin
    band_lim = {1'b0, held_q} + {{(PCT_W + 1 - BAND_W){1'b0}}, cfg_i.hold_band};
    take     = ({1'b0, lvl_q} > band_lim) || (lvl_q < held_q);
    pct      = (chg_q || take) ? lvl_q : held_q;
  end

  assign div_num = seg_diff[LDIV_NUM_W-1:0];
  assign div_den = SEG_DIV[seg_idx];

  bvg_div #(
    .NUM_W (LDIV_NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    wr_ptr_d   = wr_ptr_q;
    fill_cnt_d = fill_cnt_q;
    fill_d     = fill_q;
    sum_d      = sum_q;
    last_d     = last_q;
    held_d     = held_q;
    raw_d      = raw_q;
    cur_d      = cur_q;
    chg_d      = chg_q;
    volt_d     = volt_q;
    a_d        = a_q;
    seg_off_d  = seg_off_q;
    lvl_d      = lvl_q;
    win_we     = 1'b0;
    div_start  = 1'b0;
    job_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          raw_d     = job_i.raw_mv;
          cur_d     = job_i.charge_current;
          chg_d     = job_i.charging;
          state_d   = B_CLASS;
        end
      end
      B_CLASS: begin
        if (jump) begin
          // refill: every slot takes the new sample
          fill_d     = raw_q;
          fill_cnt_d = '0;
          sum_d      = sum_fill;
          volt_d     = raw_q;
          state_d    = B_LEVEL;
        end else begin
          win_we    = 1'b1;
          wr_ptr_d  = (wr_ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : wr_ptr_q + 1'b1;
          if (fill_cnt_q != CNT_W'(WINDOW_LEN)) begin
            fill_cnt_d = fill_cnt_q + 1'b1;
          end
          sum_d     = sum_shift;
          state_d   = B_AVG;
        end
      end
      B_AVG: begin
        volt_d  = avg_quot;
        state_d = B_LEVEL;
      end
      B_LEVEL: begin
        last_d  = volt_q;
        a_d     = {{(LVL_A_W - MV_W){1'b0}}, volt_q} * LVL_A_W'(100);
        state_d = B_SEG;
      end
      B_SEG: begin
        if (!seg_hit) begin
          lvl_d   = '0;
          state_d = B_PUSH;
        end else if (SEG_DIV[seg_idx] == '0) begin
          lvl_d   = SEG_OFFSET[seg_idx];
          state_d = B_PUSH;
        end else begin
          seg_off_d = SEG_OFFSET[seg_idx];
          div_start = 1'b1;
          state_d   = B_LDIV;
        end
      end
      B_LDIV: begin
        if (div_done) begin
          lvl_d   = seg_off_q + div_quot[PCT_W-1:0];
          state_d = B_PUSH;
        end
      end
      B_PUSH: begin
        res_push_o = 1'b1;
        if (!res_full_i) begin
          if (!chg_q && take) begin
            held_d = lvl_q;
          end
          state_d = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      wr_ptr_q   <= '0;
      fill_cnt_q <= '0;
      fill_q     <= '0;
      sum_q      <= '0;
      last_q     <= '0;
      held_q     <= '0;
    end else begin
      state_q    <= state_d;
      wr_ptr_q   <= wr_ptr_d;
      fill_cnt_q <= fill_cnt_d;
      fill_q     <= fill_d;
      sum_q      <= sum_d;
      last_q     <= last_d;
      held_q     <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q     <= raw_d;
    cur_q     <= cur_d;
    chg_q     <= chg_d;
    volt_q    <= volt_d;
    a_q       <= a_d;
    seg_off_q <= seg_off_d;
    lvl_q     <= lvl_d;
  end

  // window memory, registered read of the oldest slot
  always_ff @(posedge clk_i) begin
    if (win_we) begin
      win_mem[wr_ptr_q] <= raw_q;
    end
    old_q <= win_mem[wr_ptr_q];
  end

  assign res_o = '{voltage_mv: volt_q, charge_current: cur_q, percent_tenths: pct};

endmodule

@@ hdl/battery_voltage_gauge_core.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_gauge_core
// A sample takes longer to reach the output queue while charging, as the
// charge ratio needs a second divide; a zero reference skips the divides.
// Throughput is set by the front, which takes no new sample until it has pushed
// the last one, and runs its shared divider once per ratio; the back needs less.
// Reset: registers take their default values, window, last voltage and held
// level clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module battery_voltage_gauge_core #(
  parameter int unsigned WINDOW_LEN  = bvg_pkg::WINDOW_LEN_DEF,
  parameter int unsigned QUEUE_DEPTH = bvg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  bvg_pkg::in_t                   item_i,
  output logic                           empty,
  input  logic                           pop,
  output bvg_pkg::out_t                  result_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bvg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import bvg_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic mid_push, mid_full, mid_pop, mid_empty;
  job_t mid_in, mid_out;
  logic res_push, res_full;
  out_t res_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_JUMP_THRESHOLD: cfg_d.jump_threshold = cfg_data_i[THR_W-1:0];
        REG_HOLD_BAND:      cfg_d.hold_band      = cfg_data_i[BAND_W-1:0];
        REG_VOLTAGE_SCALE:  cfg_d.voltage_scale  = cfg_data_i[SCALE_W-1:0];
        REG_CURRENT_SCALE:  cfg_d.current_scale  = cfg_data_i[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{jump_threshold: JUMP_THRESHOLD_RST, hold_band: HOLD_BAND_RST,
                 voltage_scale: VOLTAGE_SCALE_RST, current_scale: CURRENT_SCALE_RST};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bvg_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .job_push_o (mid_push),
    .job_o      (mid_in),
    .job_full_i (mid_full)
  );

  bvg_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .data_t (job_t)
  ) u_mid_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty)
  );

  bvg_back #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (mid_out),
    .job_empty_i (mid_empty),
    .job_pop_o   (mid_pop),
    .res_push_o  (res_push),
    .res_o       (res_data),
    .res_full_i  (res_full)
  );

  bvg_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .data_t (out_t)
  ) u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  // the front is busy right after it takes a sample
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front did not go busy after an input transfer");

  a_mid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mid_push && !mid_full) |=> !mid_empty)
    else $error("converted sample lost between front and back");

  a_res_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && !res_full) |=> !empty)
    else $error("result lost on its way to the output queue");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (result_o.percent_tenths <= LEVEL_FULL))
    else $error("charge level above full scale");

endmodule

@@ verif/battery_voltage_gauge_core_test.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_gauge_core_test
// Self-checking bench for the gauge core. A probe table opens the run, then
// random readings follow under several register settings. Most of them come
// from a slowly drifting cell voltage, and the rest are raw noise. A local
// model of the filter, the current scaling and the level hold predicts each
// reading the table does not fix, and the bench compares all field by field.
// ----------------------------------------------------------------------------
module battery_voltage_gauge_core_test;
  import bvg_pkg::*;

  localparam int unsigned WIN_LEN      = WINDOW_LEN_DEF;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned PHASE_COUNT  = 6;
  localparam int unsigned PROBE_COUNT  = 24;
  localparam logic        KNOWN        = 1'b1;
  localparam logic        PREDICTED    = 1'b0;
  localparam out_t        NO_WANT      = '0;

  // level curve over mV * 100
  localparam int unsigned CURVE_BASE [12] = '{
    417900, 406300, 394900, 384500, 376000, 369500,
    364800, 361300, 357600, 352100, 348000, 342600
  };
  localparam int unsigned CURVE_OFS [12] = '{
    1000, 900, 800, 700, 600, 500, 400, 300, 200, 100, 50, 0
  };
  localparam int unsigned CURVE_DIV [12] = '{
    0, 116, 114, 104, 85, 65, 47, 35, 37, 55, 41, 54
  };

  typedef struct packed {
    logic known;
    in_t  stim;
    out_t want;
  } probe_row_t;

  localparam probe_row_t PROBES [PROBE_COUNT] = '{
    {KNOWN,     12'd0,    12'd1,    12'd0,    1'b0, 16'd0, 16'd0, 10'd0},
    {KNOWN,     12'd0,    12'd0,    12'd0,    1'b0, 16'hFFFF, 16'd0, 10'd1000},
    // zero reference while charging, window sum wraps
    {PREDICTED, 12'd0,    12'd0,    12'hFFF,  1'b1, NO_WANT},
    {PREDICTED, 12'hFFF,  12'hFFF,  12'hFFF,  1'b1, NO_WANT},
    {PREDICTED, 12'hFFF,  12'd1,    12'd0,    1'b0, NO_WANT},
    {PREDICTED, 12'hFFF,  12'd0,    12'd0,    1'b1, NO_WANT},
    {PREDICTED, 12'hAAA,  12'h555,  12'h555,  1'b1, NO_WANT},
    {PREDICTED, 12'h555,  12'hAAA,  12'hAAA,  1'b0, NO_WANT},
    // walk up through the curve segments
    {PREDICTED, 12'd3430, 12'd2480, 12'd100,  1'b0, NO_WANT},
    {PREDICTED, 12'd3485, 12'd2480, 12'd200,  1'b0, NO_WANT},
    {PREDICTED, 12'd3525, 12'd2480, 12'd900,  1'b1, NO_WANT},
    {PREDICTED, 12'd3580, 12'd2480, 12'd1500, 1'b1, NO_WANT},
    {PREDICTED, 12'd3615, 12'd2480, 12'd300,  1'b0, NO_WANT},
    {PREDICTED, 12'd3650, 12'd2480, 12'd0,    1'b0, NO_WANT},
    {PREDICTED, 12'd3700, 12'd2480, 12'd2500, 1'b1, NO_WANT},
    {PREDICTED, 12'd3765, 12'd2480, 12'd40,   1'b0, NO_WANT},
    {PREDICTED, 12'd3850, 12'd2480, 12'd50,   1'b0, NO_WANT},
    {PREDICTED, 12'd3950, 12'd2480, 12'd4000, 1'b1, NO_WANT},
    {PREDICTED, 12'd4070, 12'd2480, 12'd60,   1'b0, NO_WANT},
    // hold: small drop, rise inside the band, then charging and a big drop
    {PREDICTED, 12'd4180, 12'd2480, 12'd70,   1'b0, NO_WANT},
    {PREDICTED, 12'd4175, 12'd2480, 12'd80,   1'b0, NO_WANT},
    {PREDICTED, 12'd4185, 12'd2480, 12'd90,   1'b0, NO_WANT},
    {PREDICTED, 12'd4100, 12'd2480, 12'd3000, 1'b1, NO_WANT},
    {PREDICTED, 12'd3400, 12'd2480, 12'd10,   1'b0, NO_WANT}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  in_t                   item_i;
  logic                  empty;
  logic                  pop;
  out_t                  result_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // gauge model state
  cfg_t        gauge_cfg;
  logic [15:0] window_mv [WIN_LEN];
  logic [15:0] last_mv;
  logic [9:0]  held_pct;

  out_t        pending_readings [$];
  int unsigned fail_count;
  bit          send_steady;
  bit          take_steady;
  int          cell_mv;
  bit          on_charger;

  battery_voltage_gauge_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ratio_of(logic [11:0] num, logic [11:0] den);
    if (den == '0) return '1;
    return {4'd0, num, 16'd0} / {20'd0, den};
  endfunction

  function automatic int unsigned level_of_mv(logic [15:0] mv);
    int unsigned a;
    a = 32'(mv) * 100;
    for (int i = 0; i < 12; i++) begin
      if (a >= CURVE_BASE[i]) begin
        if (CURVE_DIV[i] == 0) return CURVE_OFS[i];
        return CURVE_OFS[i] + (a - CURVE_BASE[i]) / CURVE_DIV[i];
      end
    end
    return 0;
  endfunction

  function automatic void reset_gauge_model();
    gauge_cfg.jump_threshold = JUMP_THRESHOLD_RST;
    gauge_cfg.hold_band      = HOLD_BAND_RST;
    gauge_cfg.voltage_scale  = VOLTAGE_SCALE_RST;
    gauge_cfg.current_scale  = CURRENT_SCALE_RST;
    for (int i = 0; i < WIN_LEN; i++) window_mv[i] = '0;
    last_mv  = '0;
    held_pct = '0;
  endfunction

  function automatic out_t predict_reading(in_t stim);
    logic [31:0] prod;
    logic [31:0] scaled;
    logic [15:0] raw_mv;
    logic [15:0] sum;
    logic [15:0] volt;
    logic [15:0] cur;
    int unsigned lvl;
    out_t        res;
    prod   = ratio_of(stim.battery_raw, stim.reference_raw) * 32'(gauge_cfg.voltage_scale);
    raw_mv = prod[30:15];
    // jump test is exact, no wrap
    if (32'(raw_mv) > 32'(last_mv) + 32'(gauge_cfg.jump_threshold) ||
        32'(raw_mv) + 32'(gauge_cfg.jump_threshold) < 32'(last_mv)) begin
      for (int i = 0; i < WIN_LEN; i++) window_mv[i] = raw_mv;
      volt = raw_mv;
    end else begin
      for (int i = 0; i < WIN_LEN - 1; i++) window_mv[i] = window_mv[i + 1];
      window_mv[WIN_LEN - 1] = raw_mv;
      sum = '0;
      for (int i = 0; i < WIN_LEN; i++) sum = sum + window_mv[i];
      volt = sum / 16'(WIN_LEN);
    end
    last_mv = volt;

    if (stim.charger_present) begin
      prod   = ratio_of(stim.charge_raw, stim.reference_raw) * 32'(gauge_cfg.current_scale);
      scaled = (prod / 32'd25) * 32'd10;
      cur    = scaled[31:16];
    end else begin
      cur = '0;
    end

    lvl = level_of_mv(volt);
    if (!stim.charger_present) begin
      if (lvl > 32'(held_pct) + 32'(gauge_cfg.hold_band) || lvl < 32'(held_pct))
        held_pct = lvl[9:0];
      else
        lvl = held_pct;
    end

    res.voltage_mv     = volt;
    res.charge_current = cur;
    res.percent_tenths = lvl[9:0];
    return res;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_JUMP_THRESHOLD: gauge_cfg.jump_threshold = data[THR_W-1:0];
      REG_HOLD_BAND:      gauge_cfg.hold_band      = data[BAND_W-1:0];
      REG_VOLTAGE_SCALE:  gauge_cfg.voltage_scale  = data[SCALE_W-1:0];
      REG_CURRENT_SCALE:  gauge_cfg.current_scale  = data[SCALE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(64, 16);
  endfunction

  function automatic in_t make_item();
    in_t         it;
    int unsigned r;
    longint      bat;
    r = $urandom_range(99);
    if (r < 3) on_charger = ~on_charger;
    if (r < 72) begin
      // drifting cell seen through a jittery reference
      if (r < 6) cell_mv = $urandom_range(4300, 3300);
      else cell_mv = cell_mv + int'($urandom_range(60)) - 30;
      if (cell_mv < 3300) cell_mv = 3300;
      if (cell_mv > 4300) cell_mv = 4300;
      it.reference_raw = 12'($urandom_range(1700, 1100));
      if (gauge_cfg.voltage_scale == '0) begin
        bat = $urandom_range(4095);
      end else begin
        bat = (longint'(cell_mv) * it.reference_raw) / (2 * longint'(gauge_cfg.voltage_scale));
      end
      if (bat > 4095) bat = 4095;
      it.battery_raw     = 12'(bat);
      it.charge_raw      = 12'($urandom_range(4095));
      it.charger_present = on_charger;
    end else begin
      it = in_t'($urandom);
      it.battery_raw   = 12'($urandom);
      if (r < 80) it.reference_raw = '0;
    end
    return it;
  endfunction

  task automatic send_item(in_t stim, logic known, out_t want);
    int unsigned gap;
    out_t        guess;
    gap = pick_gap(send_steady);
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push   <= 1'b1;
    item_i <= stim;
    do @(posedge clk_i); while (full);
    guess = predict_reading(stim);
    pending_readings.push_back(known ? want : guess);
  endtask

  task automatic hold_off_and_drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_all_regs(logic [15:0] thr, logic [15:0] band, logic [15:0] vs,
                              logic [15:0] cs);
    write_reg(REG_JUMP_THRESHOLD, thr);
    write_reg(REG_HOLD_BAND, band);
    write_reg(REG_VOLTAGE_SCALE, vs);
    write_reg(REG_CURRENT_SCALE, cs);
  endtask

  // result side
  initial begin
    out_t want;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      int unsigned gap;
      gap = pick_gap(take_steady);
      @(negedge clk_i);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading %0d mV %0d cur %0d tenths", $time,
                 result_o.voltage_mv, result_o.charge_current, result_o.percent_tenths);
        fail_count++;
      end else begin
        want = pending_readings.pop_front();
        if (result_o.voltage_mv !== want.voltage_mv) begin
          $display("%0t: voltage_mv expected %0d actual %0d", $time,
                   want.voltage_mv, result_o.voltage_mv);
          fail_count++;
        end
        if (result_o.charge_current !== want.charge_current) begin
          $display("%0t: charge_current expected %0d actual %0d", $time,
                   want.charge_current, result_o.charge_current);
          fail_count++;
        end
        if (result_o.percent_tenths !== want.percent_tenths) begin
          $display("%0t: percent_tenths expected %0d actual %0d", $time,
                   want.percent_tenths, result_o.percent_tenths);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(8_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    push        = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    fail_count  = 0;
    send_steady = 1'b0;
    take_steady = 1'b0;
    cell_mv     = 3800;
    on_charger  = 1'b0;
    rst_ni      = 1'b0;
    reset_gauge_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < PROBE_COUNT; i++) begin
      send_item(PROBES[i].stim, PROBES[i].known, PROBES[i].want);
    end

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase != 0) begin
        hold_off_and_drain();
        case (phase)
          1: set_all_regs(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
          2: set_all_regs(16'd4095, 16'd1000, 16'd0, 16'd0);
          3: begin
            set_all_regs(16'd50, 16'd25, 16'd1240, 16'd1193);
            // unmapped index must leave every register alone
            write_reg(REG_CURRENT_SCALE + 3'($urandom_range(4, 1)), 16'($urandom));
          end
          4: set_all_regs(16'($urandom_range(4095)), 16'($urandom_range(1000)),
                          16'($urandom), 16'($urandom));
          default: set_all_regs(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom));
        endcase
      end
      send_steady = (phase == 2);
      take_steady = (phase == 2) || (phase == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(make_item(), PREDICTED, NO_WANT);
      end
    end

    hold_off_and_drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
